FILE: rtl/bmt_pkg.sv
// Package for the bag multiset table: action and status codes, transaction types.
// No dependencies.
`default_nettype none
package bmt_pkg;

   localparam int ACTION_BITS = 4;
   localparam int COST_BITS   = 24;
   localparam int TOTAL_BITS  = 28;
   localparam int IN_KEY_BITS = 32;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 4'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DEL1   = 4'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DELKEY = 4'd2;
   localparam logic [ACTION_BITS-1:0] ACT_COUNT  = 4'd3;
   localparam logic [ACTION_BITS-1:0] ACT_INDEX  = 4'd4;
   localparam logic [ACTION_BITS-1:0] ACT_MAX    = 4'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SUM    = 4'd6;
   localparam logic [ACTION_BITS-1:0] ACT_SORT   = 4'd7;
   localparam logic [ACTION_BITS-1:0] ACT_READ   = 4'd8;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] key;
      logic [23:0] cost;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  match_count;
      logic [4:0]  position;
      logic [31:0] key_out;
      logic [23:0] cost_out;
      logic [27:0] cost_total;
      logic [4:0]  fill;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/bag_multiset_table.sv
// Bag multiset table: a fixed-capacity bag of (key, cost) entries.
// Depends on bmt_pkg.
//
// Usage: one action per request transaction on req_ (valid/ready); one
// response transaction per request on rsp_. The block works on one request
// at a time with one shared compare/add datapath that visits one entry per
// cycle under a small sequencer. Entries live in register arrays.
// Steps from acceptance to response: insert, read, sum and unknown actions
// go straight to the sum pass. Count, index, max and delete by key first scan
// all entries; a delete by key whose key is found then shifts the entries
// above its first match down. Delete first shifts from entry 0. Sort (n >= 2)
// runs bubble passes, one adjacent pair per cycle, each pass one pair shorter,
// then the sum.
// The sum pass that gives cost_total on every response walks all entries.
// After the response is taken the block returns to idle and can accept again.
// Reset empties the bag (fill zero); entry contents are left as they are.
// A stalled response holds in the output register; req_ready stays low
// until the response has been taken.
`default_nettype none
module bag_multiset_table #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire bmt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output bmt_pkg::rsp_type     rsp_data
);
   import bmt_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_SORT = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [KEY_BITS-1:0]  keys_ff [CAPACITY];
   logic [COST_BITS-1:0] costs_ff [CAPACITY];

   logic [2:0]            state_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         lim_ff;
   logic                  found_ff;
   req_type               req_ff;
   logic [1:0]            status_ff;
   logic [CW-1:0]         hits_ff;
   logic [CW-1:0]         pos_ff;
   logic [KEY_BITS-1:0]   kout_ff;
   logic [COST_BITS-1:0]  cout_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic                  rsp_valid_ff;

   logic [KEY_BITS-1:0] key_m;
   logic [IW-1:0]       ix;
   logic [IW-1:0]       ix1;
   logic                key_hit;
   logic [TOTAL_BITS:0] sum_w;

   assign key_m   = KEY_BITS'(req_ff.key);
   assign ix      = idx_ff[IW-1:0];
   assign ix1     = IW'(idx_ff + CW'(1));
   assign key_hit = (keys_ff[ix] == key_m);
   assign sum_w   = {1'b0, total_ff} + (TOTAL_BITS+1)'(costs_ff[ix]);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencer and shared datapath: one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  idx_ff     <= '0;
                  status_ff  <= ST_OK;
                  hits_ff    <= '0;
                  pos_ff     <= '0;
                  kout_ff    <= '0;
                  cout_ff    <= '0;
                  total_ff   <= '0;
                  found_ff   <= 1'b0;
                  lim_ff     <= count_ff;
                  state_ff   <= S_SUM;
                  case (req_data.action)
                     ACT_INSERT: begin
                        if (count_ff >= CW'(CAPACITY)) status_ff <= ST_FULL;
                        else begin
                           keys_ff[count_ff[IW-1:0]]  <= KEY_BITS'(req_data.key);
                           costs_ff[count_ff[IW-1:0]] <= req_data.cost;
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     ACT_DEL1: begin
                        if (count_ff == '0) status_ff <= ST_EMPTY;
                        else begin
                           found_ff <= 1'b1;
                           state_ff <= S_SHIFT;
                        end
                     end
                     ACT_DELKEY, ACT_COUNT, ACT_INDEX, ACT_MAX: begin
                        if (req_data.action == ACT_MAX && count_ff == '0)
                           status_ff <= ST_EMPTY;
                        else state_ff <= S_SCAN;
                     end
                     ACT_SORT: begin
                        if (count_ff > CW'(1)) state_ff <= S_SORT;
                     end
                     ACT_READ: begin
                        if (CW'(req_data.slot) < count_ff && 32'(req_data.slot) < CAPACITY)
                        begin
                           kout_ff <= keys_ff[req_data.slot[IW-1:0]];
                           cout_ff <= costs_ff[req_data.slot[IW-1:0]];
                        end else status_ff <= ST_EMPTY;
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               if (idx_ff >= count_ff) begin
                  idx_ff <= '0;
                  state_ff <= S_SUM;
                  if (req_ff.action == ACT_INDEX) begin
                     pos_ff <= found_ff ? pos_ff : count_ff;
                     if (!found_ff) status_ff <= ST_EMPTY;
                  end
                  if (req_ff.action == ACT_DELKEY) begin
                     if (!found_ff) status_ff <= ST_EMPTY;
                     else begin
                        idx_ff <= pos_ff;
                        state_ff <= S_SHIFT;
                     end
                  end
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  if (key_hit) begin
                     hits_ff <= hits_ff + CW'(1);
                     if (!found_ff) begin
                        found_ff <= 1'b1;
                        pos_ff   <= idx_ff;
                     end
                  end
                  if (req_ff.action == ACT_MAX &&
                      (idx_ff == '0 || costs_ff[ix] > cout_ff)) begin
                     kout_ff <= keys_ff[ix];
                     cout_ff <= costs_ff[ix];
                  end
               end
            end
            S_SHIFT: begin
               // close the gap one entry a cycle
               if (idx_ff + CW'(1) >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  idx_ff   <= '0;
                  state_ff <= S_SUM;
               end else begin
                  keys_ff[ix]  <= keys_ff[ix1];
                  costs_ff[ix] <= costs_ff[ix1];
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_SORT: begin
               // one adjacent compare/swap a cycle; lim_ff shrinks per pass
               if (idx_ff + CW'(1) >= lim_ff) begin
                  idx_ff <= '0;
                  lim_ff <= lim_ff - CW'(1);
                  if (lim_ff <= CW'(2)) state_ff <= S_SUM;
               end else begin
                  if (costs_ff[ix] > costs_ff[ix1]) begin
                     keys_ff[ix]   <= keys_ff[ix1];
                     costs_ff[ix]  <= costs_ff[ix1];
                     keys_ff[ix1]  <= keys_ff[ix];
                     costs_ff[ix1] <= costs_ff[ix];
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_SUM: begin
               if (idx_ff >= count_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_RESP;
               end else begin
                  total_ff <= sum_w[TOTAL_BITS] ? TOTAL_MAX : sum_w[TOTAL_BITS-1:0];
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Response fields
   always_comb begin
      rsp_data             = '0;
      rsp_data.status      = status_ff;
      rsp_data.match_count = (req_ff.action == ACT_COUNT) ? 5'(hits_ff) : 5'd0;
      rsp_data.position    = (req_ff.action == ACT_INDEX) ? 5'(pos_ff) : 5'd0;
      rsp_data.key_out     = 32'(kout_ff);
      rsp_data.cost_out    = cout_ff;
      rsp_data.cost_total  = total_ff;
      rsp_data.fill        = 5'(count_ff);
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("fill beyond capacity");
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_SUM) else $error("response not after sum");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> count_ff <= $past(count_ff) + CW'(1))
      else $error("fill grew by more than one");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the bag multiset table: directed and random actions, stall bursts.
// Depends on bmt_pkg and bag_multiset_table.
`default_nettype none
module testbench;
   import bmt_pkg::*;

   localparam int CAP = 16;
   localparam int N_RANDOM = 1700;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;

   bag_multiset_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // shadow bag contents
   logic [31:0] bag_keys [CAP];
   logic [23:0] bag_costs [CAP];
   int          bag_fill;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      mismatches;
   int      cycle_count;
   int      quiet_after;
   int      sent_count;
   int      req_gap;
   int      rsp_gap;
   bit      stim_done;

   // drop entry at pos and close the gap
   function automatic void bag_remove(int pos);
      for (int i = pos; i + 1 < bag_fill; i++) begin
         bag_keys[i] = bag_keys[i + 1];
         bag_costs[i] = bag_costs[i + 1];
      end
      bag_fill--;
   endfunction

   // apply one action to the shadow bag, return the expected response
   function automatic rsp_type bag_apply(req_type rq);
      rsp_type r;
      int p;
      logic [28:0] acc;
      logic [31:0] tk;
      logic [23:0] tc;
      r = '0;
      r.status = ST_OK;
      case (rq.action)
         ACT_INSERT: begin
            if (bag_fill >= CAP) r.status = ST_FULL;
            else begin
               bag_keys[bag_fill] = rq.key;
               bag_costs[bag_fill] = rq.cost;
               bag_fill++;
            end
         end
         ACT_DEL1: begin
            if (bag_fill == 0) r.status = ST_EMPTY;
            else bag_remove(0);
         end
         ACT_DELKEY, ACT_INDEX: begin
            p = bag_fill;
            for (int i = bag_fill - 1; i >= 0; i--)
               if (bag_keys[i] == rq.key) p = i;
            if (p >= bag_fill) r.status = ST_EMPTY;
            else if (rq.action == ACT_DELKEY) bag_remove(p);
            if (rq.action == ACT_INDEX) r.position = p[4:0];
         end
         ACT_COUNT: begin
            for (int i = 0; i < bag_fill; i++)
               if (bag_keys[i] == rq.key) r.match_count++;
         end
         ACT_MAX: begin
            if (bag_fill == 0) r.status = ST_EMPTY;
            else begin
               p = 0;
               for (int i = 1; i < bag_fill; i++)
                  if (bag_costs[i] > bag_costs[p]) p = i;
               r.key_out = bag_keys[p];
               r.cost_out = bag_costs[p];
            end
         end
         ACT_SORT: begin
            for (int i = 0; i + 1 < bag_fill; i++)
               for (int j = 0; j + 1 < bag_fill - i; j++)
                  if (bag_costs[j] > bag_costs[j + 1]) begin
                     tk = bag_keys[j];
                     tc = bag_costs[j];
                     bag_keys[j] = bag_keys[j + 1];
                     bag_costs[j] = bag_costs[j + 1];
                     bag_keys[j + 1] = tk;
                     bag_costs[j + 1] = tc;
                  end
         end
         ACT_READ: begin
            if (rq.slot < bag_fill) begin
               r.key_out = bag_keys[rq.slot];
               r.cost_out = bag_costs[rq.slot];
            end else r.status = ST_EMPTY;
         end
         default: ;
      endcase
      acc = '0;
      for (int i = 0; i < bag_fill; i++) begin
         acc = acc + bag_costs[i];
         if (acc > TOTAL_MAX) acc = TOTAL_MAX;
      end
      r.cost_total = acc[27:0];
      r.fill = bag_fill[4:0];
      return r;
   endfunction

   function automatic req_type make_req(logic [3:0] act, logic [31:0] k,
                                        logic [23:0] c, logic [3:0] s);
      req_type rq;
      rq.action = act;
      rq.key = k;
      rq.cost = c;
      rq.slot = s;
      return rq;
   endfunction

   // generate the clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // fill the queue of pending transactions
   initial begin
      logic [31:0] key_pool [4];
      int pick;
      logic [3:0] act;
      logic [31:0] k;
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0;
      key_pool[2] = $urandom;
      key_pool[3] = $urandom;
      // directed: empty-bag cases, extremes, overflow, every action
      pending_reqs.push_back(make_req(ACT_DEL1, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_MAX, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_INDEX, 32'h5, 0, 0));
      pending_reqs.push_back(make_req(ACT_DELKEY, 32'h5, 0, 0));
      for (int i = 0; i < CAP; i++)
         pending_reqs.push_back(make_req(ACT_INSERT, (i % 3 == 0) ? 32'hFFFF_FFFF : i,
                                         (i % 4 == 0) ? 24'hFF_FFFF : 24'(100 - i), 0));
      pending_reqs.push_back(make_req(ACT_INSERT, 32'h7, 24'h1, 0));
      pending_reqs.push_back(make_req(ACT_SUM, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_COUNT, 32'hFFFF_FFFF, 0, 0));
      pending_reqs.push_back(make_req(ACT_MAX, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_SORT, 0, 0, 0));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 4'hF));
      pending_reqs.push_back(make_req(4'hF, 0, 0, 0));
      // random: small key pool so searches hit, mixed with noise
      for (int n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) act = ACT_INSERT;
         else if (pick < 95) act = 4'($urandom_range(1, 8));
         else act = 4'($urandom_range(9, 15));
         k = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 3)];
         pending_reqs.push_back(make_req(act, k,
            ($urandom_range(0, 7) == 0) ? 24'hFF_FFFF : 24'($urandom), 4'($urandom)));
      end
   end

   // hold reset, then release it
   initial begin
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
   end

   // drive request transactions
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
         req_gap <= 0;
         sent_count <= 0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else if (req_gap > 0) begin
         req_valid <= 0;
         req_gap <= req_gap - 1;
      end else if (pending_reqs.size() > 0 &&
                   !(sent_count < N_RANDOM && $urandom_range(0, 9) == 0)) begin
         req_valid <= 1;
         req_data <= pending_reqs.pop_front();
         sent_count <= sent_count + 1;
         if (sent_count < N_RANDOM - 100 && $urandom_range(0, 5) == 0)
            req_gap <= $urandom_range(1, 8);
      end else begin
         req_valid <= 0;
         if (pending_reqs.size() == 0) stim_done <= 1;
      end
   end

   // predict on each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(bag_apply(req_data));
   end

   // stall the response side in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else if (sent_count < N_RANDOM - 100 && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 0;
         rsp_gap <= $urandom_range(0, 7);
      end else rsp_ready <= 1;
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", exp_rsp, rsp_data);
            end
         end
      end
   end

   // watch for drain and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stim_done && !req_valid && expected_rsps.size() == 0)
         quiet_after <= quiet_after + 1;
      else quiet_after <= 0;
      if (quiet_after == 300) begin
         if (mismatches == 0) $display("Regression PASS");
         else $display("Regression FAIL");
         $finish;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      mismatches = 0;
      cycle_count = 0;
      quiet_after = 0;
      sent_count = 0;
      req_gap = 0;
      rsp_gap = 0;
      stim_done = 0;
      bag_fill = 0;
   end
endmodule
`default_nettype wire

FILE: sim.f
rtl/bmt_pkg.sv
rtl/bag_multiset_table.sv
tb/testbench.sv
